[rtl/fdmd_pkg.sv]
// Shared constants and types for the frame difference motion detector.
`timescale 1ns / 1ps
package fdmd_pkg;

   localparam int MAX_PIXELS      = 8388608;
   localparam int CHAN_WIDTH      = 8;
   localparam int THRESH_WIDTH    = 8;
   localparam int SENS_WIDTH      = 7;
   localparam int DIM_WIDTH       = 12;
   localparam int COUNT_WIDTH     = 23;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam int PRODUCT_WIDTH   = 16;
   localparam int LEN_CALC_WIDTH  = 25;
   localparam int COUNT100_WIDTH  = 30;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SENSITIVITY     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT    = 2'd3;

   localparam logic [CHAN_WIDTH-1:0] WEIGHT_RED   = 8'd77;
   localparam logic [CHAN_WIDTH-1:0] WEIGHT_GREEN = 8'd150;
   localparam logic [CHAN_WIDTH-1:0] WEIGHT_BLUE  = 8'd29;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 8'd30;
   localparam logic [SENS_WIDTH-1:0]   SENS_RESET   = 7'd5;
   localparam logic [DIM_WIDTH-1:0]    WIDTH_RESET  = 12'd1920;
   localparam logic [DIM_WIDTH-1:0]    HEIGHT_RESET = 12'd1080;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = 23'h7FFFFF;
   localparam logic [SENS_WIDTH-1:0]  PERCENT_SCALE = 7'd100;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic valid;
      logic last;
   } pipe_ctl_type;

endpackage

[rtl/fdmd_req_if.sv]
// Pixel input channel of the motion detector.
`timescale 1ns / 1ps
interface fdmd_req_if;
   logic                            valid;
   logic                            ready;
   logic [fdmd_pkg::CHAN_WIDTH-1:0] red;
   logic [fdmd_pkg::CHAN_WIDTH-1:0] green;
   logic [fdmd_pkg::CHAN_WIDTH-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/fdmd_rsp_if.sv]
// Result channel of the motion detector.
`timescale 1ns / 1ps
interface fdmd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             moving;
   logic                             frame_end;
   logic [fdmd_pkg::COUNT_WIDTH-1:0] moving_count;
   logic                             significant;

   modport source (output valid, moving, frame_end, moving_count, significant, input ready);
   modport sink (input valid, moving, frame_end, moving_count, significant, output ready);
endinterface

[rtl/fdmd_ram.sv]
// Generic simple dual-port RAM with registered read-first output.
`timescale 1ns / 1ps
module fdmd_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/fdmd_diff.sv]
// Weighted absolute color difference and per-pixel motion decision, two stages.
`timescale 1ns / 1ps
module fdmd_diff (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  fdmd_pkg::pipe_ctl_type              a_ctl,
   input  fdmd_pkg::pixel_type                 a_pix,
   input  logic                                a_fresh,
   input  fdmd_pkg::pixel_type                 prev,
   input  logic [fdmd_pkg::THRESH_WIDTH-1:0]   threshold,
   output fdmd_pkg::pipe_ctl_type              c_ctl,
   output logic                                c_moving
);
   import fdmd_pkg::*;

   function automatic logic [PRODUCT_WIDTH-1:0] weigh(input logic [CHAN_WIDTH-1:0] a,
                                                      input logic [CHAN_WIDTH-1:0] b,
                                                      input logic [CHAN_WIDTH-1:0] w);
      logic [CHAN_WIDTH-1:0] gap;
      gap = (a > b) ? a - b : b - a;
      return PRODUCT_WIDTH'(gap) * PRODUCT_WIDTH'(w);
   endfunction

   pixel_type              old_pix;
   pipe_ctl_type           b_ctl_ff, b_ctl_in;
   logic [PRODUCT_WIDTH-1:0] b_red_ff, b_red_in;
   logic [PRODUCT_WIDTH-1:0] b_green_ff, b_green_in;
   logic [PRODUCT_WIDTH-1:0] b_blue_ff, b_blue_in;
   pipe_ctl_type           c_ctl_ff, c_ctl_in;
   logic                   c_moving_ff, c_moving_in;
   logic [PRODUCT_WIDTH-1:0] sum;

   // Until the store has seen a whole frame, the previous pixel reads as black.
   assign old_pix = a_fresh ? '0 : prev;

   always_comb begin
      b_ctl_in    = b_ctl_ff;
      b_red_in    = b_red_ff;
      b_green_in  = b_green_ff;
      b_blue_in   = b_blue_ff;
      c_ctl_in    = c_ctl_ff;
      c_moving_in = c_moving_ff;
      sum         = b_red_ff + b_green_ff + b_blue_ff;
      if (advance) begin
         b_ctl_in    = a_ctl;
         b_red_in    = weigh(a_pix.red, old_pix.red, WEIGHT_RED);
         b_green_in  = weigh(a_pix.green, old_pix.green, WEIGHT_GREEN);
         b_blue_in   = weigh(a_pix.blue, old_pix.blue, WEIGHT_BLUE);
         c_ctl_in    = b_ctl_ff;
         c_moving_in = sum[PRODUCT_WIDTH-1 -: CHAN_WIDTH] > threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else begin
         b_ctl_ff <= b_ctl_in;
         c_ctl_ff <= c_ctl_in;
      end
      b_red_ff    <= b_red_in;
      b_green_ff  <= b_green_in;
      b_blue_ff   <= b_blue_in;
      c_moving_ff <= c_moving_in;
   end

   assign c_ctl    = c_ctl_ff;
   assign c_moving = c_moving_ff;
endmodule

[rtl/fdmd_stats.sv]
// Running motion count, frame significance test and the result register.
`timescale 1ns / 1ps
module fdmd_stats #(
   parameter int SigWidth = fdmd_pkg::COUNT100_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   clear,
   input  fdmd_pkg::pipe_ctl_type c_ctl,
   input  logic                   c_moving,
   input  logic [SigWidth-1:0]    sens_len,
   fdmd_rsp_if.source             rsp
);
   import fdmd_pkg::*;

   logic [COUNT_WIDTH-1:0]    count_ff, count_in, count_next;
   logic [COUNT100_WIDTH-1:0] c100_ff, c100_in, c100_next;
   logic                      inc;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_moving_ff, rsp_moving_in;
   logic                      rsp_frame_end_ff, rsp_frame_end_in;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;
   logic                      rsp_significant_ff, rsp_significant_in;

   // The count is kept alongside its hundredfold so the percent test is one compare.
   always_comb begin
      inc        = c_ctl.valid && c_moving && (count_ff != COUNT_MAX);
      count_next = count_ff + COUNT_WIDTH'(inc);
      c100_next  = c100_ff + (inc ? COUNT100_WIDTH'(PERCENT_SCALE) : '0);

      count_in           = count_ff;
      c100_in            = c100_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_moving_in      = rsp_moving_ff;
      rsp_frame_end_in   = rsp_frame_end_ff;
      rsp_count_in       = rsp_count_ff;
      rsp_significant_in = rsp_significant_ff;

      if (clear) begin
         count_in = '0;
         c100_in  = '0;
      end else if (advance) begin
         rsp_valid_in       = c_ctl.valid;
         rsp_moving_in      = c_moving;
         rsp_frame_end_in   = c_ctl.last;
         rsp_count_in       = count_next;
         rsp_significant_in = c_ctl.last && (SigWidth'(c100_next) >= sens_len);
         if (c_ctl.valid) begin
            count_in = c_ctl.last ? '0 : count_next;
            c100_in  = c_ctl.last ? '0 : c100_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         c100_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         c100_ff      <= c100_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_moving_ff      <= rsp_moving_in;
      rsp_frame_end_ff   <= rsp_frame_end_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_significant_ff <= rsp_significant_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.moving       = rsp_moving_ff;
   assign rsp.frame_end    = rsp_frame_end_ff;
   assign rsp.moving_count = rsp_count_ff;
   assign rsp.significant  = rsp_significant_ff;
endmodule

[rtl/frame_difference_motion_detect.sv]
// Top level of the frame difference motion detector.
//
//   Channel | Direction | Carries
//   req     | in        | red, green, blue of one pixel, raster order
//   rsp     | out       | moving, frame_end, moving_count, significant
//   csr     | in        | write enable, register index, write data
//
// One pixel is accepted every clock cycle while the result is not stalled;
// each result is registered in the a, b and c stages and then the result
// register. The frame store is one RAM read and written at the same address
// in the cycle a pixel is accepted, so the port pair sets the rate.
// Reset is synchronous. The store is not swept: after reset or a size write,
// the first frame compares against black. A stalled result stalls the whole
// pipeline and req.ready falls with it.
`timescale 1ns / 1ps
module frame_difference_motion_detect #(
   parameter int MaxPixels = fdmd_pkg::MAX_PIXELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   fdmd_req_if.sink                               req,
   fdmd_rsp_if.source                             rsp,
   input  logic                                   csr_write_en,
   input  logic [fdmd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fdmd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import fdmd_pkg::*;

   localparam int PosWidth = $clog2(MaxPixels);
   localparam int SigWidth = (PosWidth + SENS_WIDTH + 1 > COUNT100_WIDTH) ?
                             PosWidth + SENS_WIDTH + 1 : COUNT100_WIDTH;

   function automatic logic [PosWidth-1:0] last_pos_of(input logic [DIM_WIDTH-1:0] w,
                                                       input logic [DIM_WIDTH-1:0] h);
      logic [LEN_CALC_WIDTH-1:0] n;
      n = LEN_CALC_WIDTH'(w) * LEN_CALC_WIDTH'(h);
      if (n == '0) begin
         n = LEN_CALC_WIDTH'(1);
      end
      if (n > LEN_CALC_WIDTH'(MaxPixels)) begin
         n = LEN_CALC_WIDTH'(MaxPixels);
      end
      return PosWidth'(n - LEN_CALC_WIDTH'(1));
   endfunction

   localparam logic [PosWidth-1:0] LastPosReset = last_pos_of(WIDTH_RESET, HEIGHT_RESET);

   logic [THRESH_WIDTH-1:0] thresh_ff, thresh_in;
   logic [SENS_WIDTH-1:0]   sens_ff, sens_in;
   logic [DIM_WIDTH-1:0]    width_ff, width_in;
   logic [DIM_WIDTH-1:0]    height_ff, height_in;
   logic [PosWidth-1:0]     last_pos_ff, last_pos_in;
   logic [SigWidth-1:0]     sens_len_ff, sens_len_in;
   logic                    size_write;

   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic                    filled_ff, filled_in;
   logic                    advance;
   logic                    accept;
   logic                    is_last;

   pipe_ctl_type            a_ctl_ff, a_ctl_in;
   pixel_type               a_pix_ff, a_pix_in;
   logic                    a_fresh_ff, a_fresh_in;
   pixel_type               new_pix;
   pixel_type               prev_pix;
   pipe_ctl_type            c_ctl;
   logic                    c_moving;
   logic [PosWidth:0]       frame_len;

   always_comb begin
      thresh_in   = thresh_ff;
      sens_in     = sens_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      last_pos_in = last_pos_ff;
      size_write  = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PIXEL_THRESHOLD: begin
               thresh_in = csr_wdata[THRESH_WIDTH-1:0];
            end
            CSR_SENSITIVITY: begin
               sens_in = csr_wdata[SENS_WIDTH-1:0];
            end
            CSR_FRAME_WIDTH: begin
               width_in    = csr_wdata[DIM_WIDTH-1:0];
               last_pos_in = last_pos_of(csr_wdata[DIM_WIDTH-1:0], height_ff);
               size_write  = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in   = csr_wdata[DIM_WIDTH-1:0];
               last_pos_in = last_pos_of(width_ff, csr_wdata[DIM_WIDTH-1:0]);
               size_write  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign frame_len   = {1'b0, last_pos_ff} + (PosWidth + 1)'(1);
   assign sens_len_in = SigWidth'(sens_ff) * SigWidth'(frame_len);

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;
   assign is_last   = (pos_ff == last_pos_ff);
   assign new_pix   = '{red: req.red, green: req.green, blue: req.blue};

   always_comb begin
      pos_in     = pos_ff;
      filled_in  = filled_ff;
      a_ctl_in   = a_ctl_ff;
      a_pix_in   = a_pix_ff;
      a_fresh_in = a_fresh_ff;
      if (size_write) begin
         pos_in    = '0;
         filled_in = 1'b0;
      end else if (accept) begin
         pos_in = is_last ? '0 : pos_ff + PosWidth'(1);
         if (is_last) begin
            filled_in = 1'b1;
         end
      end
      if (advance) begin
         a_ctl_in   = '{valid: accept, last: is_last};
         a_pix_in   = new_pix;
         a_fresh_in = !filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_RESET;
         sens_ff     <= SENS_RESET;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         last_pos_ff <= LastPosReset;
         pos_ff      <= '0;
         filled_ff   <= 1'b0;
         a_ctl_ff    <= '0;
      end else begin
         thresh_ff   <= thresh_in;
         sens_ff     <= sens_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         last_pos_ff <= last_pos_in;
         pos_ff      <= pos_in;
         filled_ff   <= filled_in;
         a_ctl_ff    <= a_ctl_in;
      end
      sens_len_ff <= sens_len_in;
      a_pix_ff    <= a_pix_in;
      a_fresh_ff  <= a_fresh_in;
   end

   // Read and write share the address; the read returns the pixel from the last frame.
   fdmd_ram #(
      .Width ($bits(pixel_type)),
      .Depth (MaxPixels)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (new_pix),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (prev_pix)
   );

   fdmd_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .a_ctl     (a_ctl_ff),
      .a_pix     (a_pix_ff),
      .a_fresh   (a_fresh_ff),
      .prev      (prev_pix),
      .threshold (thresh_ff),
      .c_ctl     (c_ctl),
      .c_moving  (c_moving)
   );

   fdmd_stats #(
      .SigWidth (SigWidth)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .clear    (size_write),
      .c_ctl    (c_ctl),
      .c_moving (c_moving),
      .sens_len (sens_len_ff),
      .rsp      (rsp)
   );
endmodule
